// File: hw/rtl/first_fit_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// first_fit_block_allocator assertion macros
// Concurrent assertion shorthands used by the allocator's checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types, codes and default sizes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	// Default sizing
	localparam int DEF_MAX_BLOCKS   = 64;
	localparam int DEF_HEAP_BYTES   = 65536;
	localparam int DEF_HEADER_BYTES = 40;

	// Request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NULL    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	// One block table entry
	typedef struct packed {
		logic [15:0] offset;
		logic [15:0] size;
		logic        free_flag;
	} entry_t;

	// Sequencer states
	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

endpackage

// File: hw/rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_ram
	import ffba_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_BLOCKS,
	parameter int AW    = $clog2(DEF_MAX_BLOCKS)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];

	// Write and synchronous read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over an address-ordered table of blocks.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Allocate and free
// requests walk the block table, held in a memory with one read and one write
// port, one entry per cycle with the read of the next entry overlapping the
// check of the current one. A walk stops at the first matching entry or
// after the last live entry (allocate miss, unknown free address). Null
// requests (zero-byte allocate, free of address 0) return in the next cycle
// and do not raise busy. Each result is shown for exactly one cycle with done
// high and must be captured then: there is no way to hold it off. busy falls
// in the cycle the result is shown, so the next request may be presented then.
// The block table needs no clearing after reset.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
	parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [15:0] req_bytes,
	input  logic [15:0] payload_addr,
	output logic        done,
	output logic [15:0] granted_addr,
	output logic [1:0]  status,
	output logic [16:0] heap_top
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_BLOCKS);
	localparam logic [17:0]      HEAP_LIM  = (HEAP_BYTES > 65536) ? 18'd65536
	                                         : 18'(HEAP_BYTES);
	localparam logic [16:0]      HDR       = 17'(HEADER_BYTES);

	state_t state_q, state_d;

	// Request and heap state
	logic             kind_q;
	logic [15:0]      req_q;
	logic [15:0]      addr_q;
	logic [CNT_W-1:0] count_q;
	logic [16:0]      break_q;
	logic [CNT_W-1:0] idx_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	// Memory ports
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             rd_en;
	entry_t           rd_data;

	// Decision signals
	logic        accept;
	logic        null_req;
	logic        alloc_hit;
	logic        free_hit;
	logic        hit;
	logic        more;
	logic        miss;
	logic        finish;
	logic        at_top;
	logic [16:0] span;
	logic [16:0] shrunk_break;
	logic [16:0] new_base;
	logic [17:0] new_end;
	logic        fits;
	logic        grow_ok;
	logic        shrink;

	// Next result
	logic [15:0] res_granted;
	logic [1:0]  res_status;
	logic [16:0] res_top;
	logic        res_load;

	ffba_ram #(
		.DEPTH (MAX_BLOCKS),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign busy     = (state_q == S_SCAN);
	assign accept   = start && !busy;
	assign null_req = (kind == KIND_ALLOC) ? (req_bytes == 16'd0) : (payload_addr == 16'd0);

	// Entry check on the data read last cycle
	assign alloc_hit = chk_vld_s1 && (kind_q == KIND_ALLOC) && rd_data.free_flag
	                   && (rd_data.size >= req_q);
	assign free_hit  = chk_vld_s1 && (kind_q == KIND_FREE) && (rd_data.offset == addr_q);
	assign hit       = alloc_hit || free_hit;
	assign more      = (idx_q < count_q);
	assign miss      = !chk_vld_s1 && !more;
	assign finish    = busy && (hit || miss);
	assign rd_en     = busy && more && !hit;

	// Free of the top block
	assign at_top       = (({1'b0, addr_q} + {1'b0, rd_data.size}) == break_q);
	assign span         = HDR + {1'b0, rd_data.size};
	assign shrunk_break = (span <= break_q) ? (break_q - span) : 17'd0;
	assign shrink       = free_hit && at_top;

	// Append at the break on an allocate miss
	assign new_base = break_q + HDR;
	assign new_end  = {1'b0, break_q} + {1'b0, HDR} + {2'b00, req_q};
	assign fits     = ({1'b0, break_q} <= HEAP_LIM) && (new_end <= HEAP_LIM);
	assign grow_ok  = busy && miss && (kind_q == KIND_ALLOC) && (count_q < MAX_CNT) && fits;

	// Next state and outputs
	always_comb begin
		state_d     = state_q;
		wr_en       = 1'b0;
		wr_addr     = chk_idx_s1;
		wr_data     = rd_data;
		res_load    = 1'b0;
		res_granted = 16'd0;
		res_status  = ST_OK;
		res_top     = break_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (null_req) begin
						res_load   = 1'b1;
						res_status = ST_NULL;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (finish) begin
					state_d  = S_IDLE;
					res_load = 1'b1;
				end
				if (alloc_hit) begin
					wr_en             = 1'b1;
					wr_data.free_flag = 1'b0;
					res_granted       = rd_data.offset;
				end else if (free_hit) begin
					if (at_top) begin
						res_top = shrunk_break;
					end else begin
						wr_en             = 1'b1;
						wr_data.free_flag = 1'b1;
					end
				end else if (miss) begin
					if (kind_q == KIND_FREE) begin
						res_status = ST_UNKNOWN;
					end else if (grow_ok) begin
						wr_en       = 1'b1;
						wr_addr     = count_q[IDX_W-1:0];
						wr_data     = '{offset: new_base[15:0], size: req_q, free_flag: 1'b0};
						res_granted = new_base[15:0];
						res_top     = new_end[16:0];
					end else begin
						res_status = ST_FULL;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: table fill, break, scan pointer, check valid, done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			break_q    <= '0;
			idx_q      <= '0;
			chk_vld_s1 <= 1'b0;
			done       <= 1'b0;
		end else begin
			done       <= res_load;
			chk_vld_s1 <= rd_en;
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (grow_ok) begin
				count_q <= count_q + 1'b1;
				break_q <= new_end[16:0];
			end else if (shrink) begin
				count_q <= CNT_W'(chk_idx_s1);
				break_q <= shrunk_break;
			end
		end
	end

	// Request capture, scan index and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			req_q  <= req_bytes;
			addr_q <= payload_addr;
		end
		if (rd_en) begin
			chk_idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (res_load) begin
			granted_addr <= res_granted;
			status       <= res_status;
			heap_top     <= res_top;
		end
	end

endmodule

// File: hw/rtl/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks on the first-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_assert.svh"

module ffba_checker
	import ffba_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] granted_addr,
	input logic [1:0]  status,
	input logic [16:0] heap_top
);

	// A result only appears once the walk is over
	`FFBA_ASSERT_SAME(a_done_not_busy, clk, arst_n, done, !busy, "result shown while busy")

	// A taken item either starts a walk or answers at once
	`FFBA_ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, busy || done, "item taken but neither busy nor done")

	// End of a walk always yields a result
	`FFBA_ASSERT_SAME(a_busy_fall_done, clk, arst_n, $fell(busy), done, "walk ended without result")

	// Failed requests grant nothing; grants lie below the break
	`FFBA_ASSERT_SAME(a_grant_sane, clk, arst_n, done && (granted_addr != 16'd0), (status == ST_OK) && ({1'b0, granted_addr} < heap_top), "grant inconsistent with status or break")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.granted_addr (granted_addr),
	.status       (status),
	.heap_top     (heap_top)
);

// File: dv/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking bench for the first-fit block allocator. A directed opener
// covers null requests, hits, misses, double frees, top removal and a full
// heap. Random allocate/free traffic follows, with periodic teardowns and
// table-filling bursts. Every result is checked against an in-bench model of
// the block table.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
	import ffba_pkg::*;

	localparam int HDR_BYTES  = DEF_HEADER_BYTES;
	localparam int TABLE_SIZE = DEF_MAX_BLOCKS;
	localparam int HEAP_LIMIT = (DEF_HEAP_BYTES > 65536) ? 65536 : DEF_HEAP_BYTES;
	localparam int RAND_ITEMS = 1500;

	typedef struct {
		logic        kind;
		logic [15:0] req_bytes;
		logic [15:0] payload_addr;
		bit          no_gap;
	} heap_request_t;

	typedef struct {
		logic        kind;
		logic [15:0] granted;
		logic [1:0]  status;
		logic [16:0] top;
	} heap_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        kind = KIND_ALLOC;
	logic [15:0] req_bytes = '0;
	logic [15:0] payload_addr = '0;
	logic        done;
	logic [15:0] granted_addr;
	logic [1:0]  status;
	logic [16:0] heap_top;

	// Model of the block table
	logic [15:0] blk_off [TABLE_SIZE];
	logic [15:0] blk_size [TABLE_SIZE];
	bit          blk_free [TABLE_SIZE];
	int          blk_count = 0;
	int          heap_brk = 0;

	heap_request_t request_q [$];
	heap_result_t  awaited_q [$];
	logic [15:0]   granted_pool [$];
	heap_request_t in_flight;
	int            items_taken = 0;
	int            results_seen = 0;
	int            errors = 0;
	int            counted = 0;

	first_fit_block_allocator uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.req_bytes   (req_bytes),
		.payload_addr(payload_addr),
		.done        (done),
		.granted_addr(granted_addr),
		.status      (status),
		.heap_top    (heap_top)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20ms;
		$display("tb_first_fit_block_allocator: FAIL");
		$finish;
	end

	// Work out the result of one request and update the table model
	function automatic heap_result_t predict_heap_result(heap_request_t rq);
		heap_result_t r;
		int           i;
		int           hit;
		int           total;
		int           span;
		r.kind    = rq.kind;
		r.granted = '0;
		r.status  = ST_OK;
		hit       = -1;
		if (rq.kind == KIND_ALLOC) begin
			if (rq.req_bytes == 0) begin
				r.status = ST_NULL;
			end else begin
				for (i = 0; i < blk_count; i++)
					if (hit < 0 && blk_free[i] && blk_size[i] >= rq.req_bytes)
						hit = i;
				total = HDR_BYTES + int'(rq.req_bytes);
				if (hit >= 0) begin
					blk_free[hit] = 1'b0;
					r.granted     = blk_off[hit];
				end else if (blk_count >= TABLE_SIZE || total > HEAP_LIMIT - heap_brk) begin
					r.status = ST_FULL;
				end else begin
					blk_off[blk_count]  = 16'(heap_brk + HDR_BYTES);
					blk_size[blk_count] = rq.req_bytes;
					blk_free[blk_count] = 1'b0;
					r.granted           = 16'(heap_brk + HDR_BYTES);
					blk_count++;
					heap_brk += total;
				end
			end
		end else if (rq.payload_addr == 0) begin
			r.status = ST_NULL;
		end else begin
			for (i = 0; i < blk_count; i++)
				if (hit < 0 && blk_off[i] == rq.payload_addr)
					hit = i;
			if (hit < 0) begin
				r.status = ST_UNKNOWN;
			end else if (int'(rq.payload_addr) + int'(blk_size[hit]) == heap_brk) begin
				// block ends at the top: drop it and lower the break
				span      = HDR_BYTES + int'(blk_size[hit]);
				heap_brk  = (span <= heap_brk) ? heap_brk - span : 0;
				blk_count = hit;
			end else begin
				blk_free[hit] = 1'b1;
			end
		end
		r.top = 17'(heap_brk);
		return r;
	endfunction

	// Driver: presents queued items, idling at random between them
	always @(posedge clk) begin
		heap_request_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				awaited_q.push_back(predict_heap_result(in_flight));
				items_taken++;
			end
			if (!start || !busy) begin
				if (request_q.size() != 0 && (request_q[0].no_gap || $urandom_range(99) >= 32)) begin
					nxt          = request_q.pop_front();
					in_flight    = nxt;
					start        <= 1'b1;
					kind         <= nxt.kind;
					req_bytes    <= nxt.req_bytes;
					payload_addr <= nxt.payload_addr;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each strobed result against the oldest expectation
	always @(posedge clk) begin
		heap_result_t want;
		bit           known;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (awaited_q.size() == 0) begin
				$error("result with nothing expected: granted_addr %0d status %0d heap_top %0d",
					granted_addr, status, heap_top);
				errors++;
			end else begin
				want = awaited_q.pop_front();
				if (granted_addr !== want.granted) begin
					$error("granted_addr: expected %0d, got %0d", want.granted, granted_addr);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (heap_top !== want.top) begin
					$error("heap_top: expected %0d, got %0d", want.top, heap_top);
					errors++;
				end
				// remember granted offsets so later frees mostly hit live blocks
				if (want.kind == KIND_ALLOC && want.status == ST_OK) begin
					known = 1'b0;
					foreach (granted_pool[i])
						if (granted_pool[i] == want.granted)
							known = 1'b1;
					if (!known)
						granted_pool.push_back(want.granted);
					if (granted_pool.size() > 96)
						void'(granted_pool.pop_front());
				end
			end
		end
	end

	task automatic queue_request(input logic k, input logic [15:0] nbytes,
			input logic [15:0] addr);
		heap_request_t rq;
		rq.kind         = k;
		rq.req_bytes    = nbytes;
		rq.payload_addr = addr;
		rq.no_gap       = (counted >= 700 && counted < 900);
		while (request_q.size() >= 4)
			@(negedge clk);
		request_q.push_back(rq);
		if ((k == KIND_ALLOC && nbytes != 0) || (k == KIND_FREE && addr != 0))
			counted++;
	endtask

	task automatic wait_all_results();
		while (request_q.size() != 0 || start || items_taken != results_seen)
			@(negedge clk);
	endtask

	// Stimulus
	initial begin
		logic [15:0] snap [$];
		int          next_teardown;
		int          pick;
		int          idx;
		bit          burst;
		next_teardown = 0;
		burst         = 1'b1;

		// Directed: null requests, hit, miss, double free, top removal, heap full
		queue_request(KIND_ALLOC, 16'd0, 16'hFFFF);
		queue_request(KIND_FREE, 16'hFFFF, 16'd0);
		queue_request(KIND_FREE, 16'd0, 16'h1234);
		queue_request(KIND_ALLOC, 16'd1, 16'd0);
		queue_request(KIND_ALLOC, 16'd100, 16'd0);
		queue_request(KIND_ALLOC, 16'd50, 16'd0);
		queue_request(KIND_FREE, 16'd0, 16'd81);
		queue_request(KIND_ALLOC, 16'd60, 16'd0);
		queue_request(KIND_FREE, 16'd0, 16'd81);
		queue_request(KIND_FREE, 16'd0, 16'd81);
		queue_request(KIND_ALLOC, 16'd200, 16'd0);
		queue_request(KIND_FREE, 16'd0, 16'd311);
		queue_request(KIND_FREE, 16'd0, 16'd221);
		queue_request(KIND_FREE, 16'd0, 16'd81);
		queue_request(KIND_FREE, 16'd0, 16'd40);
		queue_request(KIND_FREE, 16'd0, 16'd40);
		queue_request(KIND_ALLOC, 16'hFFFF, 16'd0);
		queue_request(KIND_ALLOC, 16'(HEAP_LIMIT - HDR_BYTES), 16'd0);
		queue_request(KIND_ALLOC, 16'd1, 16'd0);
		queue_request(KIND_FREE, 16'd0, 16'hFFFF);
		queue_request(KIND_FREE, 16'd0, 16'd40);

		// Random traffic
		counted = 0;
		while (counted < RAND_ITEMS) begin
			if (counted >= next_teardown) begin
				// sender holds off until the block has answered everything
				wait_all_results();
				snap = granted_pool;
				granted_pool.delete();
				for (int i = snap.size() - 1; i >= 0; i--)
					queue_request(KIND_FREE, 16'($urandom), snap[i]);
				// fill the table past its capacity
				if (burst)
					for (int i = 0; i < 70; i++)
						queue_request(KIND_ALLOC, 16'($urandom_range(1, 32)), 16'($urandom));
				burst         = !burst;
				next_teardown += 200;
			end
			pick = $urandom_range(99);
			if (pick < 55) begin
				pick = $urandom_range(99);
				if (pick < 70)
					queue_request(KIND_ALLOC, 16'($urandom_range(1, 256)), 16'($urandom));
				else if (pick < 85)
					queue_request(KIND_ALLOC, 16'($urandom_range(257, 4096)), 16'($urandom));
				else if (pick < 90)
					queue_request(KIND_ALLOC, 16'd0, 16'($urandom));
				else
					queue_request(KIND_ALLOC, 16'($urandom), 16'($urandom));
			end else begin
				pick = $urandom_range(99);
				if (granted_pool.size() != 0 && pick < 75) begin
					idx = $urandom_range(granted_pool.size() - 1);
					queue_request(KIND_FREE, 16'($urandom), granted_pool[idx]);
				end else if (granted_pool.size() != 0 && pick < 85) begin
					idx = $urandom_range(granted_pool.size() - 1);
					if ($urandom_range(1))
						queue_request(KIND_FREE, 16'($urandom),
							granted_pool[idx] + 16'($urandom_range(1, 8)));
					else
						queue_request(KIND_FREE, 16'($urandom),
							granted_pool[idx] - 16'($urandom_range(1, 8)));
				end else if (pick < 90) begin
					queue_request(KIND_FREE, 16'($urandom), 16'd0);
				end else begin
					queue_request(KIND_FREE, 16'($urandom), 16'($urandom));
				end
			end
		end

		wait_all_results();
		repeat (TABLE_SIZE + 8) @(negedge clk);
		if (errors == 0 && awaited_q.size() == 0)
			$display("tb_first_fit_block_allocator: PASS");
		else
			$display("tb_first_fit_block_allocator: FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ram.sv
hw/rtl/first_fit_block_allocator.sv
hw/rtl/ffba_checker.sv
dv/tb_first_fit_block_allocator.sv
